@@ src/rcg_pkg.sv @@
// Shared types and constants for the ring cadence generator.
`timescale 1ns / 1ps

package rcg_pkg;

   localparam int STEP_MS_W  = 16;
   localparam int HALF_MS_W  = 10;
   localparam int CAD_CNT_W  = 17;
   localparam int FREQ_CNT_W = 11;
   localparam int REG_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int NUM_DUR    = 4;

   localparam logic [CAD_CNT_W-1:0]  CAD_SAT  = '1;
   localparam logic [FREQ_CNT_W-1:0] FREQ_SAT = '1;

   localparam logic [STEP_MS_W-1:0] STEP0_RST = 16'd2000;
   localparam logic [STEP_MS_W-1:0] STEP1_RST = 16'd4000;
   localparam logic [STEP_MS_W-1:0] STEP2_RST = 16'd0;
   localparam logic [STEP_MS_W-1:0] STEP3_RST = 16'd0;
   localparam logic [HALF_MS_W-1:0] HALF_RST  = 10'd25;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_STEP0 = 3'd0,
      REG_STEP1 = 3'd1,
      REG_STEP2 = 3'd2,
      REG_STEP3 = 3'd3,
      REG_HALF  = 3'd4
   } rcg_reg_type;

   typedef struct packed {
      logic [NUM_DUR-1:0][STEP_MS_W-1:0] step_ms;
      logic [HALF_MS_W-1:0]              half_ms;
   } rcg_cfg_type;

   typedef struct packed {
      logic tick;
      logic start_ring;
      logic stop_ring;
      logic off_hook;
   } rcg_item_type;

   typedef struct packed {
      logic       ringing;
      logic       ring_mode_pin;
      logic       fwd_rev_pin;
      logic       ring_led;
      logic [1:0] cadence_index;
   } rcg_result_type;

endpackage

@@ src/rcg_csr.sv @@
// Configuration register file: cadence durations and ring half period.
`timescale 1ns / 1ps

module rcg_csr
   import rcg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [REG_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output rcg_cfg_type           cfg
);

   rcg_cfg_type cfg_ff;
   rcg_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (rcg_reg_type'(csr_index))
            REG_STEP0: cfg_in.step_ms[0] = csr_wdata;
            REG_STEP1: cfg_in.step_ms[1] = csr_wdata;
            REG_STEP2: cfg_in.step_ms[2] = csr_wdata;
            REG_STEP3: cfg_in.step_ms[3] = csr_wdata;
            REG_HALF:  cfg_in.half_ms    = csr_wdata[HALF_MS_W-1:0];
            default:   cfg_in = cfg_ff;   // unmapped index, dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_ms[0] <= STEP0_RST;
         cfg_ff.step_ms[1] <= STEP1_RST;
         cfg_ff.step_ms[2] <= STEP2_RST;
         cfg_ff.step_ms[3] <= STEP3_RST;
         cfg_ff.half_ms    <= HALF_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ src/rcg_cadence.sv @@
// Ring state and single-pass next-state logic for one item.
`timescale 1ns / 1ps

module rcg_cadence
   import rcg_pkg::*;
#(
   parameter int CADENCE_STEPS = 4
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           fire,
   input  rcg_item_type   item,
   input  rcg_cfg_type    cfg,
   output rcg_result_type result
);

   localparam int STEP_W = (CADENCE_STEPS > 2) ? $clog2(CADENCE_STEPS) : 1;
   localparam logic [STEP_W:0] LAST_STEP = (STEP_W+1)'(CADENCE_STEPS - 1);

   logic                  act_ff,  act_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [CAD_CNT_W-1:0]  ce_ff,   ce_in;
   logic [FREQ_CNT_W-1:0] fe_ff,   fe_in;
   logic                  tog_ff,  tog_in;
   logic                  pol_ff,  pol_in;
   logic                  mode_ff, mode_in;
   logic                  led_ff,  led_in;

   always_comb begin
      logic [2:0] step_x;
      act_in  = act_ff;
      step_in = step_ff;
      ce_in   = ce_ff;
      fe_in   = fe_ff;
      tog_in  = tog_ff;
      pol_in  = pol_ff;
      mode_in = mode_ff;
      led_in  = led_ff;

      if (item.start_ring && !item.off_hook) begin
         step_in = '0;
         ce_in   = '0;
         fe_in   = '0;
         act_in  = 1'b1;
         mode_in = 1'b1;
      end
      // stop, or handset lifted mid-ring
      if (item.stop_ring || (act_in && item.off_hook)) begin
         act_in  = 1'b0;
         mode_in = 1'b0;
         pol_in  = 1'b0;
      end

      step_x = 3'(step_in);
      if (act_in) begin
         if (item.tick) begin
            if (ce_in != CAD_SAT) ce_in = ce_in + 1'b1;
            if (fe_in != FREQ_SAT) fe_in = fe_in + 1'b1;
         end
         if (ce_in > {1'b0, cfg.step_ms[step_x[1:0]]}) begin
            ce_in = '0;
            if ({1'b0, step_in} == LAST_STEP) step_in = '0;
            else step_in = step_in + 1'b1;
         end
         step_x = 3'(step_in);
         if (!step_x[0]) begin
            if (fe_in > {1'b0, cfg.half_ms}) begin
               fe_in  = '0;
               tog_in = ~tog_in;
               pol_in = tog_in;
               led_in = tog_in;
            end
         end else begin
            pol_in = 1'b0;
            led_in = 1'b1;
         end
      end

      result.ringing       = act_in;
      result.ring_mode_pin = mode_in;
      result.fwd_rev_pin   = pol_in;
      result.ring_led      = led_in;
      result.cadence_index = step_x[1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff  <= 1'b0;
         step_ff <= '0;
         ce_ff   <= '0;
         fe_ff   <= '0;
         tog_ff  <= 1'b0;
         pol_ff  <= 1'b0;
         mode_ff <= 1'b0;
         led_ff  <= 1'b1;
      end else if (fire) begin
         act_ff  <= act_in;
         step_ff <= step_in;
         ce_ff   <= ce_in;
         fe_ff   <= fe_in;
         tog_ff  <= tog_in;
         pol_ff  <= pol_in;
         mode_ff <= mode_in;
         led_ff  <= led_in;
      end
   end

endmodule

@@ src/ring_cadence_generator.sv @@
// Top level of the telephone ring cadence generator.
//
// Usage:
//  - req_ channel: one transfer per item = one millisecond tick flag plus
//    start, stop and off-hook levels. Typically one item per clock.
//  - rsp_ channel: exactly one transfer per item, in order, carrying the
//    ringing flag, ring mode and fwd/rev pin levels, LED drive and the
//    current cadence step, all taken after that item's update.
//  - csr_ channel: register writes (index 0..3 cadence step durations in ms,
//    index 4 ring half period in ms). Always ready; unknown indexes dropped.
//    Write only while no item is in flight.
//  - A request transfer loads the input register; the state update then loads
//    the result register, which drives rsp_. Throughput: one item per clock
//    while rsp_stall is low, as the state update is a single combinational
//    pass.
//  - A stalled result holds in the result register; the input register still
//    takes one more item, and req_stall rises only when both are full.
//  - Reset (synchronous, active high) empties both registers, stops ringing,
//    turns the LED off (high) and restores the default cadence 2 s on / 4 s off
//    with a 25 ms half period.
`timescale 1ns / 1ps

module ring_cadence_generator
   import rcg_pkg::*;
#(
   parameter int CADENCE_STEPS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_tick,
   input  logic                  req_start_ring,
   input  logic                  req_stop_ring,
   input  logic                  req_off_hook,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_ringing,
   output logic                  rsp_ring_mode_pin,
   output logic                  rsp_fwd_rev_pin,
   output logic                  rsp_ring_led,
   output logic [1:0]            rsp_cadence_index,
   // configuration channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [REG_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   rcg_cfg_type    cfg;
   rcg_item_type   item_ff, item_in;
   logic           in_valid_ff, in_valid_in;
   rcg_result_type res_ff, res_in;
   logic           out_valid_ff, out_valid_in;
   logic           fire;        // input register moves into result register
   logic           req_take;

   rcg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rcg_cadence #(
      .CADENCE_STEPS (CADENCE_STEPS)
   ) u_cadence (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item_ff),
      .cfg    (cfg),
      .result (res_in)
   );

   // Result register frees up when empty or being taken this cycle.
   assign fire      = in_valid_ff && !(out_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      item_in.tick       = req_tick;
      item_in.start_ring = req_start_ring;
      item_in.stop_ring  = req_stop_ring;
      item_in.off_hook   = req_off_hook;

      in_valid_in = in_valid_ff;
      if (req_take) in_valid_in = 1'b1;
      else if (fire) in_valid_in = 1'b0;

      out_valid_in = out_valid_ff;
      if (fire) out_valid_in = 1'b1;
      else if (!rsp_stall) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) item_ff <= item_in;
      if (fire) res_ff <= res_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_ringing       = res_ff.ringing;
   assign rsp_ring_mode_pin = res_ff.ring_mode_pin;
   assign rsp_fwd_rev_pin   = res_ff.fwd_rev_pin;
   assign rsp_ring_led      = res_ff.ring_led;
   assign rsp_cadence_index = res_ff.cadence_index;

endmodule

@@ src/rcg_checker.sv @@
// Port-level assertions for the ring cadence generator, bound to the top level.
`timescale 1ns / 1ps

module rcg_checker
   import rcg_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_ringing,
   input logic       rsp_ring_mode_pin,
   input logic       rsp_fwd_rev_pin,
   input logic       rsp_ring_led,
   input logic [1:0] rsp_cadence_index
);

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_ringing)
         && $stable(rsp_fwd_rev_pin) && $stable(rsp_ring_led)
         && $stable(rsp_cadence_index) && $stable(rsp_ring_mode_pin))
      else $error("result changed under stall");

   a_mode_tracks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_ring_mode_pin == rsp_ringing)
      else $error("ring mode disagrees with ringing");

   a_idle_pin_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ringing |-> !rsp_fwd_rev_pin)
      else $error("fwd/rev driven while not ringing");

   a_gap_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ringing && rsp_cadence_index[0] |-> !rsp_fwd_rev_pin && rsp_ring_led)
      else $error("pin or LED active in silent step");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind ring_cadence_generator rcg_checker u_rcg_checker (.*);

@@ sim/tb_ring_cadence_generator.sv @@
// Self-checking testbench for the ring cadence generator, with directed and random traffic.
`timescale 1ns / 1ps

import rcg_pkg::*;

// Cadence predictor: tracks ring state per item and queues the levels it expects.
class ring_predictor;
   int unsigned              num_steps;
   logic [STEP_MS_W-1:0]     step_ms [NUM_DUR];
   logic [HALF_MS_W-1:0]     half_ms;
   logic                     active, toggle, polarity, mode, led;
   int unsigned              step_idx;
   logic [CAD_CNT_W-1:0]     cad_ms;
   logic [FREQ_CNT_W-1:0]    freq_ms;
   rcg_result_type           pending_levels [$];
   int unsigned              mismatches;
   int unsigned              responses;

   function new(int unsigned steps);
      num_steps  = steps;
      mismatches = 0;
      responses  = 0;
      step_ms[0] = STEP0_RST;
      step_ms[1] = STEP1_RST;
      step_ms[2] = STEP2_RST;
      step_ms[3] = STEP3_RST;
      half_ms    = HALF_RST;
      active     = 1'b0;
      toggle     = 1'b0;
      polarity   = 1'b0;
      mode       = 1'b0;
      led        = 1'b1;
      step_idx   = 0;
      cad_ms     = '0;
      freq_ms    = '0;
   endfunction

   function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_STEP0, REG_STEP1, REG_STEP2, REG_STEP3: step_ms[idx] = data;
         REG_HALF:                                   half_ms = data[HALF_MS_W-1:0];
         default: ;
      endcase
   endfunction

   function void halt();
      active   = 1'b0;
      mode     = 1'b0;
      polarity = 1'b0;
   endfunction

   function void take_request(rcg_item_type it);
      rcg_result_type r;
      if (it.start_ring && !it.off_hook) begin
         step_idx = 0;
         cad_ms   = '0;
         freq_ms  = '0;
         active   = 1'b1;
         mode     = 1'b1;
      end
      if (it.stop_ring) halt();
      if (active && it.off_hook) halt();
      if (active) begin
         if (it.tick) begin
            if (cad_ms != CAD_SAT) cad_ms++;
            if (freq_ms != FREQ_SAT) freq_ms++;
         end
         if (cad_ms > step_ms[step_idx % NUM_DUR]) begin
            cad_ms   = '0;
            step_idx = (step_idx + 1 >= num_steps) ? 0 : step_idx + 1;
         end
         if (step_idx % 2 == 0) begin
            if (freq_ms > half_ms) begin
               freq_ms  = '0;
               toggle   = ~toggle;
               polarity = toggle;
               led      = toggle;
            end
         end else begin
            polarity = 1'b0;
            led      = 1'b1;
         end
      end
      r.ringing       = active;
      r.ring_mode_pin = mode;
      r.fwd_rev_pin   = polarity;
      r.ring_led      = led;
      r.cadence_index = 2'(step_idx % NUM_DUR);
      pending_levels.push_back(r);
   endfunction

   function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         mismatches++;
      end
   endfunction

   function void match_response(rcg_result_type got);
      rcg_result_type exp_r;
      responses++;
      if (pending_levels.size() == 0) begin
         $error("response transfer with nothing outstanding");
         mismatches++;
         return;
      end
      exp_r = pending_levels.pop_front();
      compare_field("ringing", exp_r.ringing, got.ringing);
      compare_field("ring_mode_pin", exp_r.ring_mode_pin, got.ring_mode_pin);
      compare_field("fwd_rev_pin", exp_r.fwd_rev_pin, got.fwd_rev_pin);
      compare_field("ring_led", exp_r.ring_led, got.ring_led);
      compare_field("cadence_index", exp_r.cadence_index, got.cadence_index);
   endfunction
endclass

module tb_ring_cadence_generator;

   localparam int RING_STEPS = 4;
   localparam int PHASES     = 8;
   localparam int PHASE_LEN  = 96;
   localparam int HOLD_LEN   = 80;    // long receiver hold-off, in cycles

   // cadence set-ups used by the random phases
   typedef enum int {
      CAD_SHORT,    // short bursts and gaps, fast ring
      CAD_ZERO,     // every duration and the half period at zero
      CAD_MAX,      // every duration at its top value, half period at 1000
      CAD_MIXED     // medium values, one duration forced to zero
   } cad_kind_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_tick = 1'b0;
   logic                  req_start_ring = 1'b0;
   logic                  req_stop_ring = 1'b0;
   logic                  req_off_hook = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_ringing;
   logic                  rsp_ring_mode_pin;
   logic                  rsp_fwd_rev_pin;
   logic                  rsp_ring_led;
   logic [1:0]            rsp_cadence_index;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [REG_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   ring_predictor  sb;
   rcg_result_type seen_levels;

   int unsigned idle_pct  = 0;   // chance per cycle that the sender sits out
   int unsigned stall_pct = 0;   // chance per cycle that the receiver stalls
   int unsigned hold_left = 0;
   bit          hold_req  = 1'b0;
   int unsigned requests  = 0;
   int unsigned reg_writes = 0;
   logic        hook_level = 1'b0;

   ring_cadence_generator #(
      .CADENCE_STEPS(RING_STEPS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_tick          (req_tick),
      .req_start_ring    (req_start_ring),
      .req_stop_ring     (req_stop_ring),
      .req_off_hook      (req_off_hook),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_ringing       (rsp_ringing),
      .rsp_ring_mode_pin (rsp_ring_mode_pin),
      .rsp_fwd_rev_pin   (rsp_fwd_rev_pin),
      .rsp_ring_led      (rsp_ring_led),
      .rsp_cadence_index (rsp_cadence_index),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: well beyond the slowest legal run, pressure and stalls included.
   initial begin
      #3_000_000;
      $display("ring_cadence_generator test failed");
      $finish;
   end

   // Receiver: checks every response transfer, then picks next cycle's stall.
   // A hold-off request from the main sequence turns into a long counted stall
   // here, so only this process ever drives rsp_stall.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_levels.ringing       = rsp_ringing;
         seen_levels.ring_mode_pin = rsp_ring_mode_pin;
         seen_levels.fwd_rev_pin   = rsp_fwd_rev_pin;
         seen_levels.ring_led      = rsp_ring_led;
         seen_levels.cadence_index = rsp_cadence_index;
         sb.match_response(seen_levels);
      end
      if (hold_req) begin
         hold_req  = 1'b0;
         hold_left = HOLD_LEN;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   function automatic rcg_item_type make_item(logic t, logic st, logic sp, logic hk);
      rcg_item_type it;
      it.tick       = t;
      it.start_ring = st;
      it.stop_ring  = sp;
      it.off_hook   = hk;
      return it;
   endfunction

   // Mostly ticking ring sequences; starts, stops and hook flips are the noise.
   function automatic rcg_item_type random_item();
      if ($urandom_range(0, 99) < 3) hook_level = ~hook_level;
      return make_item($urandom_range(0, 99) < 85, $urandom_range(0, 99) < 4,
                       $urandom_range(0, 99) < 2, hook_level);
   endfunction

   // One request transfer. The payload holds while req_stall is high.
   task automatic send_item(input rcg_item_type it);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_tick       <= it.tick;
      req_start_ring <= it.start_ring;
      req_stop_ring  <= it.stop_ring;
      req_off_hook   <= it.off_hook;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.take_request(it);
      requests++;
   endtask

   // Stop offering and let every outstanding response come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_levels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes all five registers plus one unused index; block must be idle.
   task automatic program_cadence(input logic [CSR_DATA_W-1:0] s0, s1, s2, s3,
                                  input logic [CSR_DATA_W-1:0] half);
      logic [CSR_DATA_W-1:0] vals [6];
      logic [REG_IDX_W-1:0]  idx;
      vals = '{s0, s1, s2, s3, half, 16'($urandom_range(0, 65535))};
      for (int i = 0; i < 6; i++) begin
         idx = (i <= REG_HALF) ? REG_IDX_W'(i) : REG_HALF + REG_IDX_W'($urandom_range(1, 3));
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_wdata <= vals[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         sb.write_reg(idx, vals[i]);
         reg_writes++;
      end
      csr_valid <= 1'b0;
   endtask

   task automatic pick_cadence(input cad_kind_type kind);
      logic [CSR_DATA_W-1:0] d [4];
      case (kind)
         CAD_ZERO: program_cadence('0, '0, '0, '0, '0);
         CAD_MAX:  program_cadence('1, '1, '1, '1, 16'd1000);
         CAD_MIXED: begin
            foreach (d[i]) d[i] = 16'($urandom_range(0, 40));
            d[$urandom_range(0, 3)] = '0;
            program_cadence(d[0], d[1], d[2], d[3], 16'($urandom_range(0, 10)));
         end
         default: begin
            foreach (d[i]) d[i] = 16'($urandom_range(0, 6));
            program_cadence(d[0], d[1], d[2], d[3], 16'($urandom_range(0, 3)));
         end
      endcase
   endtask

   initial begin
      int unsigned  idle_pat  [4] = '{0, 74, 0, 27};
      int unsigned  stall_pat [4] = '{0, 0, 74, 27};
      cad_kind_type kinds [PHASES] = '{CAD_SHORT, CAD_SHORT, CAD_MIXED, CAD_SHORT,
                                       CAD_ZERO, CAD_MIXED, CAD_MAX, CAD_SHORT};

      sb = new(RING_STEPS);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, first at the reset cadence (2 s on, 4 s off, 25 ms).
      send_item(make_item(0, 0, 0, 0));   // idle, nothing ringing
      send_item(make_item(1, 0, 0, 1));   // off hook while idle changes nothing
      send_item(make_item(1, 1, 0, 1));   // start while off hook is ignored
      send_item(make_item(0, 1, 0, 0));   // start
      send_item(make_item(1, 0, 0, 0));
      drain();

      // Short cadence with zero-length second half and zero half period, so
      // steps advance and the polarity toggles on nearly every tick.
      program_cadence(16'd2, 16'd1, 16'd0, 16'd0, 16'd0);
      repeat (8) send_item(make_item(1, 0, 0, 0));
      send_item(make_item(0, 0, 0, 0));   // no tick: nothing counts
      send_item(make_item(1, 1, 0, 0));   // restart while ringing
      send_item(make_item(1, 1, 1, 0));   // start and stop together: stop wins
      send_item(make_item(1, 1, 0, 0));
      send_item(make_item(1, 0, 0, 1));   // handset lifted while ringing
      send_item(make_item(0, 0, 0, 0));
      send_item(make_item(1, 1, 0, 0));
      repeat (3) send_item(make_item(1, 0, 0, 0));
      send_item(make_item(1, 0, 1, 0));   // stop keeps led, toggle and step
      send_item(make_item(1, 0, 0, 0));
      drain();

      // Random phases: each gets its own cadence and idling pattern.
      for (int p = 0; p < PHASES; p++) begin
         pick_cadence(kinds[p]);
         idle_pct  = idle_pat[p % 4];
         stall_pct = stall_pat[p % 4];
         if (kinds[p] == CAD_ZERO) hold_req = 1'b1;   // sender keeps going: block backs up
         hook_level = 1'b0;
         for (int n = 0; n < (kinds[p] == CAD_MAX ? PHASE_LEN / 2 : PHASE_LEN); n++)
            send_item(random_item());
         drain();
      end

      stall_pct = 0;
      repeat (8) @(posedge clock);
      if (sb.pending_levels.size() != 0) begin
         $error("%0d expected responses never arrived", sb.pending_levels.size());
         sb.mismatches++;
      end
      $display("Covered %0d request transfers and %0d responses across %0d cadence set-ups,",
               requests, sb.responses, PHASES + 2);
      $display("with %0d register writes and %0d mismatches.", reg_writes, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("ring_cadence_generator test passed");
      end else begin
         $display("ring_cadence_generator test failed");
      end
      $finish;
   end

endmodule
